FILE: sv/hslrgb_pkg.sv
`default_nettype none

package hslrgb_pkg;

    // Fixed-point format of the hue, saturation and lightness fractions
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = FRAC_BITS + 1;     // 0..ONE inclusive
    localparam int T_W       = FRAC_BITS + 3;     // hue times six, 0..6*ONE
    localparam int V2_W      = 2 * FRAC_BITS + 1; // channel value, 2*FRAC_BITS fraction
    localparam int SC_W      = V2_W + 8;          // channel value times 255
    localparam int BYTE_HI_W = SC_W - 2 * FRAC_BITS;

    // Stream widths
    localparam int IN_DATA_W  = ((3 * VAL_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 24;

    // Pipeline depth in register stages
    localparam int NSTG = 6;

    localparam logic [VAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VAL_W-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // Hue segment boundaries, scaled by six
    localparam logic [T_W-1:0] T_ONE   = T_W'(1 << FRAC_BITS);
    localparam logic [T_W-1:0] T_TWO   = T_W'(2 << FRAC_BITS);
    localparam logic [T_W-1:0] T_THREE = T_W'(3 << FRAC_BITS);
    localparam logic [T_W-1:0] T_FOUR  = T_W'(4 << FRAC_BITS);
    localparam logic [T_W-1:0] T_SIX   = T_W'(6 << FRAC_BITS);

    // Per-stage load enables for the channel back end
    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } hslrgb_adv_t;

endpackage

`default_nettype wire

FILE: sv/hslrgb_channel.sv
`default_nettype none

module hslrgb_channel (
    input  wire logic                                  clk,
    input  wire hslrgb_pkg::hslrgb_adv_t               adv,
    input  wire logic [hslrgb_pkg::VAL_W-1:0]          p,
    input  wire logic [hslrgb_pkg::VAL_W-1:0]          d,
    input  wire logic [hslrgb_pkg::T_W-1:0]            t,
    output logic [7:0]                                 chan
);

    logic [hslrgb_pkg::VAL_W-1:0]      f_reg, f_next;
    logic [hslrgb_pkg::VAL_W-1:0]      p3_reg, d3_reg;
    logic [2*hslrgb_pkg::VAL_W-1:0]    mul_reg, mul_next;
    logic [hslrgb_pkg::VAL_W-1:0]      p4_reg;
    logic [hslrgb_pkg::V2_W-1:0]       v2_reg, v2_next;
    logic [hslrgb_pkg::SC_W-1:0]       scaled;
    logic [hslrgb_pkg::BYTE_HI_W-1:0]  byte_hi;
    logic [7:0]                        chan_reg, chan_next;

    // Pick the ramp weight for the hue segment
    always_comb
    begin
        priority if (t < hslrgb_pkg::T_ONE)
            f_next = t[hslrgb_pkg::VAL_W-1:0];
        else if (t < hslrgb_pkg::T_THREE)
            f_next = hslrgb_pkg::ONE;
        else if (t < hslrgb_pkg::T_FOUR)
            f_next = hslrgb_pkg::VAL_W'(hslrgb_pkg::T_FOUR - t);
        else
            f_next = '0;
    end

    // Weight the span between p and q
    assign mul_next = d3_reg * f_reg;

    // Add the floor value p at full precision
    assign v2_next = {p4_reg, {hslrgb_pkg::FRAC_BITS{1'b0}}}
                   + hslrgb_pkg::V2_W'(mul_reg);

    // Scale by 255, truncate, saturate
    always_comb
    begin
        scaled  = {v2_reg, 8'h00} - {8'h00, v2_reg};
        byte_hi = scaled[hslrgb_pkg::SC_W-1:2*hslrgb_pkg::FRAC_BITS];
        if (byte_hi > hslrgb_pkg::BYTE_HI_W'(255))
            chan_next = 8'hFF;
        else
            chan_next = byte_hi[7:0];
    end

    // Payload stages, loaded when the stage advances
    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            f_reg  <= f_next;
            p3_reg <= p;
            d3_reg <= d;
        end
        if (adv.s4)
        begin
            mul_reg <= mul_next;
            p4_reg  <= p3_reg;
        end
        if (adv.s5)
            v2_reg <= v2_next;
        if (adv.s6)
            chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

`default_nettype wire

FILE: sv/hsl_to_rgb_converter_top.sv
`default_nettype none
// HSL to RGB pixel converter, six register stages.
// A request taken while s_tready is high moves through the stage registers in
// order, and m_tvalid rises once it reaches the last stage.
// Throughput: one pixel per clock; each stage holds its own valid bit, and
// the ready chain from m_tready lets bubbles close up under backpressure.
// Reset clears all valid bits; data registers are not reset.
module hsl_to_rgb_converter_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // [16:0] hue, [33:17] saturation, [50:34] lightness, [55:51] zero
    input  wire logic [hslrgb_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [hslrgb_pkg::OUT_DATA_W-1:0]         m_tdata
);

    localparam int VW = hslrgb_pkg::VAL_W;
    localparam int TW = hslrgb_pkg::T_W;

    logic [hslrgb_pkg::NSTG-1:0] vld_reg, vld_next, rdy;
    hslrgb_pkg::hslrgb_adv_t     adv;

    logic [VW-1:0]   hue_in, sat_in, lgt_in;
    logic [VW-1:0]   hue_c, sat_c, lgt_c;
    logic [2*VW-1:0] ls_full;

    logic [VW-1:0]   lgt_reg, sat_reg, lss_reg;
    logic [VW-1:0]   lss_next;
    logic [TW-1:0]   hue6_reg, hue6_next;

    logic [VW:0]     q_w, p_w;
    logic [TW:0]     tr_w;
    logic [VW-1:0]   p_reg, p_next, d_reg, d_next;
    logic [TW-1:0]   tr_reg, tr_next, tg_reg, tg_next, tb_reg, tb_next;

    logic [7:0]      red, green, blue;

    // Ready chain: a stage loads when empty or when its successor moves
    always_comb
    begin
        rdy[hslrgb_pkg::NSTG-1] = !vld_reg[hslrgb_pkg::NSTG-1] || m_tready;
        for (int k = hslrgb_pkg::NSTG - 2; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < hslrgb_pkg::NSTG; k++)
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign adv.s3 = rdy[2];
    assign adv.s4 = rdy[3];
    assign adv.s5 = rdy[4];
    assign adv.s6 = rdy[5];

    // Stage 1: saturate inputs to one, form l*s and six times hue
    assign hue_in = s_tdata[VW-1:0];
    assign sat_in = s_tdata[2*VW-1:VW];
    assign lgt_in = s_tdata[3*VW-1:2*VW];

    always_comb
    begin
        hue_c     = (hue_in > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : hue_in;
        sat_c     = (sat_in > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : sat_in;
        lgt_c     = (lgt_in > hslrgb_pkg::ONE) ? hslrgb_pkg::ONE : lgt_in;
        ls_full   = lgt_c * sat_c;
        lss_next  = ls_full[hslrgb_pkg::FRAC_BITS +: VW];
        hue6_next = TW'({hue_c, 2'b00}) + TW'({hue_c, 1'b0});
    end

    // Stage 2: q, p and q - p; offset and wrap hue per channel.
    // Zero saturation falls out as p = l, q - p = 0, which gives grey.
    always_comb
    begin
        if (lgt_reg < hslrgb_pkg::HALF)
            q_w = {1'b0, lgt_reg} + {1'b0, lss_reg};
        else
            q_w = {1'b0, lgt_reg} + {1'b0, sat_reg} - {1'b0, lss_reg};
        p_w    = {lgt_reg, 1'b0} - q_w;
        p_next = p_w[VW-1:0];
        d_next = q_w[VW-1:0] - p_w[VW-1:0];

        tr_w = {1'b0, hue6_reg} + {1'b0, hslrgb_pkg::T_TWO};
        if (tr_w > {1'b0, hslrgb_pkg::T_SIX})
            tr_next = TW'(tr_w - {1'b0, hslrgb_pkg::T_SIX});
        else
            tr_next = tr_w[TW-1:0];

        tg_next = hue6_reg;

        if (hue6_reg < hslrgb_pkg::T_TWO)
            tb_next = hue6_reg + hslrgb_pkg::T_FOUR;
        else
            tb_next = hue6_reg - hslrgb_pkg::T_TWO;
    end

    // Front-end payload registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            lgt_reg  <= lgt_c;
            sat_reg  <= sat_c;
            lss_reg  <= lss_next;
            hue6_reg <= hue6_next;
        end
        if (rdy[1])
        begin
            p_reg  <= p_next;
            d_reg  <= d_next;
            tr_reg <= tr_next;
            tg_reg <= tg_next;
            tb_reg <= tb_next;
        end
    end

    // Stages 3 to 6: one back end per channel
    hslrgb_channel u_red (
        .clk  (clk),
        .adv  (adv),
        .p    (p_reg),
        .d    (d_reg),
        .t    (tr_reg),
        .chan (red)
    );

    hslrgb_channel u_green (
        .clk  (clk),
        .adv  (adv),
        .p    (p_reg),
        .d    (d_reg),
        .t    (tg_reg),
        .chan (green)
    );

    hslrgb_channel u_blue (
        .clk  (clk),
        .adv  (adv),
        .p    (p_reg),
        .d    (d_reg),
        .t    (tb_reg),
        .chan (blue)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[hslrgb_pkg::NSTG-1];
    assign m_tdata  = {blue, green, red};

`ifndef SYNTHESIS
    // An empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // q = p + d never exceeds one
    a_q_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (({1'b0, p_reg} + {1'b0, d_reg}) <= {1'b0, hslrgb_pkg::ONE}))
        else $error("q above one");

    // Wrapped hue stays within one turn for every channel
    a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (tr_reg <= hslrgb_pkg::T_SIX && tg_reg <= hslrgb_pkg::T_SIX
                        && tb_reg <= hslrgb_pkg::T_SIX))
        else $error("hue not wrapped");

    // Zero saturation leaves no span between p and q
    a_grey_span: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[0] && rdy[1] && sat_reg == '0) |=> (d_reg == '0 && p_reg == $past(lgt_reg)))
        else $error("grey request with nonzero span");

    // A result appears only by moving up from the stage before it
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(vld_reg[hslrgb_pkg::NSTG-2]))
        else $error("result valid without a request behind it");
`endif

endmodule

`default_nettype wire

FILE: bench/hsl_to_rgb_converter_top_test.sv
`timescale 1ns / 1ps

module hsl_to_rgb_converter_top_test;

    localparam int FRAC_BITS  = hslrgb_pkg::FRAC_BITS;
    localparam int VAL_W      = hslrgb_pkg::VAL_W;
    localparam int IN_DATA_W  = hslrgb_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = hslrgb_pkg::OUT_DATA_W;
    localparam int NSTG       = hslrgb_pkg::NSTG;
    localparam logic [VAL_W-1:0] ONE  = hslrgb_pkg::ONE;
    localparam logic [VAL_W-1:0] HALF = hslrgb_pkg::HALF;

    localparam int    CLK_PERIOD  = 20;
    localparam int    CYCLE_LIMIT = 200000;
    localparam longint UNIT       = longint'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] FRAC_MAX = {VAL_W{1'b1}};

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // [16:0] hue, [33:17] saturation, [50:34] lightness, [55:51] zero
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // [7:0] red, [15:8] green, [23:16] blue
    logic [OUT_DATA_W-1:0] m_tdata;

    rgb_t rgb_expected[$];
    int   error_count;
    int   cycle_count;
    bit   stall_on;

    hsl_to_rgb_converter_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Saturate a raw fraction to one
    function automatic longint sat_unit(input logic [VAL_W-1:0] raw);
        longint v;
        v = longint'(raw);
        return (v > UNIT) ? UNIT : v;
    endfunction

    // Scale a value with twice the fraction bits to a byte, truncate and clip
    function automatic logic [7:0] byte_of(input longint v2);
        longint r;
        r = (v2 * 255) >> (2 * FRAC_BITS);
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    // Piecewise hue-to-channel rule, hue carried as six times the fraction
    function automatic logic [7:0] channel_level(input longint p, input longint q,
                                                 input longint t6);
        longint t;
        longint v2;
        t = t6;
        if (t < 0)
            t = t + 6 * UNIT;
        if (t > 6 * UNIT)
            t = t - 6 * UNIT;
        if (t < UNIT)
            v2 = p * UNIT + (q - p) * t;
        else if (t < 3 * UNIT)
            v2 = q * UNIT;
        else if (t < 4 * UNIT)
            v2 = p * UNIT + (q - p) * (4 * UNIT - t);
        else
            v2 = p * UNIT;
        if (v2 < 0)
            v2 = 0;
        return byte_of(v2);
    endfunction

    // Work out the pixel a request should produce
    function automatic rgb_t rgb_of_hsl(input logic [VAL_W-1:0] hue_raw,
                                        input logic [VAL_W-1:0] sat_raw,
                                        input logic [VAL_W-1:0] light_raw);
        longint h;
        longint s;
        longint l;
        longint q;
        longint p;
        rgb_t   px;
        h = sat_unit(hue_raw);
        s = sat_unit(sat_raw);
        l = sat_unit(light_raw);
        // zero saturation is grey
        if (s == 0)
        begin
            px.red   = byte_of(l * UNIT);
            px.green = px.red;
            px.blue  = px.red;
            return px;
        end
        if (2 * l < UNIT)
            q = l + ((l * s) >> FRAC_BITS);
        else
            q = l + s - ((l * s) >> FRAC_BITS);
        p = 2 * l - q;
        px.red   = channel_level(p, q, 6 * h + 2 * UNIT);
        px.green = channel_level(p, q, 6 * h);
        px.blue  = channel_level(p, q, 6 * h - 2 * UNIT);
        return px;
    endfunction

    // Random fraction, mostly in range, sometimes at the ends or above one
    function automatic logic [VAL_W-1:0] rand_frac();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
            return VAL_W'($urandom_range(0, 65536));
        else if (pick == 7)
            return VAL_W'($urandom_range(0, 131071));
        else if (pick == 8)
            return '0;
        else
            return ONE;
    endfunction

    // Send one request; starts and ends at a falling edge with tvalid low
    task automatic send_pixel(input logic [VAL_W-1:0] hue, input logic [VAL_W-1:0] sat,
                              input logic [VAL_W-1:0] light);
        int gap;
        gap = stall_on ? $urandom_range(0, 7) : 0;
        repeat (gap) @(negedge clk);
        s_tdata  = IN_DATA_W'({light, sat, hue});
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Hold until every pending result has come back
    task automatic wait_drained();
        while (rgb_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Record accepted requests and check each accepted result
    always @(posedge clk)
    begin
        rgb_t exp_px;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                rgb_expected.push_back(rgb_of_hsl(s_tdata[VAL_W-1:0],
                                                  s_tdata[2*VAL_W-1:VAL_W],
                                                  s_tdata[3*VAL_W-1:2*VAL_W]));
            if (m_tvalid && m_tready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    $error("result with no request pending: %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    exp_px = rgb_expected.pop_front();
                    check_field("red", exp_px.red, m_tdata[7:0]);
                    check_field("green", exp_px.green, m_tdata[15:8]);
                    check_field("blue", exp_px.blue, m_tdata[23:16]);
                end
            end
        end
    end

    // Result side: when stalls are on, hold m_tready low for a random gap before taking each result
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = stall_on ? $urandom_range(0, 7) : 0;
            m_tready = 1'b0;
            repeat (gap) @(negedge clk);
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("hsl_to_rgb_converter_top_test: done, errors");
            $finish;
        end
    end

    // Zero saturation: grey from lightness, including lightness above one
    task automatic test_grey();
        send_pixel('0, '0, '0);
        send_pixel(ONE, '0, ONE);
        send_pixel(17'h12345, '0, HALF);
        send_pixel(FRAC_MAX, '0, FRAC_MAX);
        send_pixel(17'h00001, '0, 17'h00001);
    endtask

    // Field extremes, hue wrap and segment boundaries
    task automatic test_extremes();
        send_pixel(FRAC_MAX, FRAC_MAX, FRAC_MAX);
        send_pixel(ONE, ONE, ONE);
        send_pixel('0, ONE, '0);
        send_pixel('0, ONE, HALF);
        send_pixel(ONE, ONE, HALF);
        send_pixel(17'h0FFFF, 17'h0FFFF, 17'h0FFFF);
        send_pixel(17'd10922, ONE, HALF);
        send_pixel(17'd10923, ONE, HALF);
        send_pixel(17'd21845, ONE, HALF);
        send_pixel(17'd21846, ONE, HALF);
        send_pixel(17'd32768, 17'd40000, 17'd32767);
        send_pixel(17'd43690, 17'd40000, 17'd32768);
        send_pixel(17'd43691, 17'd40000, 17'd20000);
        send_pixel(17'd54613, 17'd1, 17'd50000);
        send_pixel(17'd54614, FRAC_MAX, 17'd1);
    endtask

    // Random pixels with random gaps on both sides
    task automatic test_random_stream(input int count);
        stall_on = 1'b1;
        repeat (count) send_pixel(rand_frac(), rand_frac(), rand_frac());
    endtask

    // Full rate on both sides
    task automatic test_back_to_back(input int count);
        stall_on = 1'b0;
        repeat (count) send_pixel(rand_frac(), rand_frac(), rand_frac());
        stall_on = 1'b1;
    endtask

    // Short bursts, each drained before the next
    task automatic test_drain_pause(input int bursts);
        repeat (bursts)
        begin
            repeat ($urandom_range(1, 12)) send_pixel(rand_frac(), rand_frac(), rand_frac());
            wait_drained();
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        stall_on    = 1'b1;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        rst_n       = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_grey();
        test_extremes();
        test_random_stream(1400);
        test_back_to_back(250);
        test_drain_pause(20);

        wait_drained();
        repeat (NSTG + 4) @(negedge clk);
        if (error_count == 0)
            $display("hsl_to_rgb_converter_top_test: done, clean");
        else
            $display("hsl_to_rgb_converter_top_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
sv/hslrgb_pkg.sv
sv/hslrgb_channel.sv
sv/hsl_to_rgb_converter_top.sv
bench/hsl_to_rgb_converter_top_test.sv
